// File: src/camb_pkg.sv
package camb_pkg;

  localparam int unsigned VecFracBits = 14;
  localparam int unsigned Q30Shift    = 30;
  localparam int unsigned VecToQ30    = Q30Shift - VecFracBits;
  localparam int unsigned ProdToQ30   = Q30Shift - 2 * VecFracBits;

  localparam logic signed [33:0] CordicGain  = 34'sd652032874;
  localparam logic signed [19:0] DegToRad    = 20'sd292818;
  localparam logic signed [16:0] FullTurn    = 17'sd23040;
  localparam logic signed [16:0] HalfTurn    = 17'sd11520;
  localparam logic signed [16:0] QuarterTurn = 17'sd5760;

  localparam logic signed [15:0] VecOne  = 16'sd16384;
  localparam logic signed [31:0] PosResZ = -32'sd2560;

  localparam logic KindAngles = 1'b0;
  localparam logic KindMove   = 1'b1;

  typedef logic signed [15:0] vec_t;
  typedef logic signed [31:0] pos_t;
  typedef logic signed [32:0] raw_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORD_Y,
    S_CORD_P,
    S_RAW,
    S_SQ,
    S_SQRT_GO,
    S_SQRT,
    S_DIV_GO,
    S_DIV,
    S_COMMIT,
    S_UPM,
    S_MOVE,
    S_FIN
  } camb_state_e;

  typedef enum logic [1:0] {
    PH_FRONT,
    PH_RIGHT,
    PH_UP
  } camb_phase_e;

  typedef enum logic [1:0] {
    DIR_FWD,
    DIR_BACK,
    DIR_LEFT,
    DIR_RIGHT
  } camb_dir_e;

  // arctan(2^-i) in q2.30 radians
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: src/camb_cordic.sv
module camb_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [15:0]    angle_i,
  output camb_pkg::unit_sts_t   sts_o,
  output logic signed [31:0]    cos_o,
  output logic signed [31:0]    sin_o
);

  localparam int unsigned CntW = $clog2(STEPS + 1);

  logic                   busy_q, done_q, neg_q, neg_d;
  logic [CntW-1:0]        cnt_q;
  logic signed [33:0]     x_q, y_q, x_d, y_d, x_sh, y_sh;
  logic signed [32:0]     z_q, z_d, atan_s;
  logic signed [16:0]     a_ext, r_wrap, r_half, r_fold;
  logic signed [36:0]     z_start;

  // reduce to one turn, then fold into [-90, 90] degrees
  always_comb begin
    a_ext = 17'(angle_i);
    if (a_ext >= camb_pkg::FullTurn) begin
      r_wrap = a_ext - camb_pkg::FullTurn;
    end else if (a_ext >= 17'sd0) begin
      r_wrap = a_ext;
    end else if (a_ext >= -camb_pkg::FullTurn) begin
      r_wrap = a_ext + camb_pkg::FullTurn;
    end else begin
      r_wrap = a_ext + camb_pkg::FullTurn + camb_pkg::FullTurn;
    end
    r_half = (r_wrap >= camb_pkg::HalfTurn) ? r_wrap - camb_pkg::FullTurn : r_wrap;
    neg_d  = 1'b0;
    r_fold = r_half;
    if (r_half > camb_pkg::QuarterTurn) begin
      r_fold = r_half - camb_pkg::HalfTurn;
      neg_d  = 1'b1;
    end else if (r_half < -camb_pkg::QuarterTurn) begin
      r_fold = r_half + camb_pkg::HalfTurn;
      neg_d  = 1'b1;
    end
    z_start = 37'(r_fold) * 37'(camb_pkg::DegToRad);
  end

  always_comb begin
    x_sh   = x_q >>> cnt_q;
    y_sh   = y_q >>> cnt_q;
    atan_s = $signed({1'b0, camb_pkg::atan_q30(5'(cnt_q))});
    if (!z_q[32]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan_s;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= camb_pkg::CordicGain;
      y_q   <= '0;
      z_q   <= 33'(z_start);
      neg_q <= neg_d;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign cos_o = neg_q ? 32'(-x_q) : 32'(x_q);
  assign sin_o = neg_q ? 32'(-y_q) : 32'(y_q);

endmodule

// File: src/camb_sqrt.sv
module camb_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         x_i,
  output camb_pkg::unit_sts_t sts_o,
  output logic [31:0]         root_o
);

  logic        busy_q, done_q;
  logic [63:0] rem_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= x_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o = res_q[31:0];

endmodule

// File: src/camb_div.sv
module camb_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [31:0]                     mag_i,
  input  logic [31:0]                     len_i,
  output camb_pkg::unit_sts_t             sts_o,
  output logic [camb_pkg::VecFracBits:0]  quot_o
);

  localparam int unsigned NumW = 32 + camb_pkg::VecFracBits + 1;
  localparam int unsigned CntW = $clog2(camb_pkg::VecFracBits + 1);

  logic                           busy_q, done_q, ge;
  logic [CntW-1:0]                cnt_q;
  logic [NumW-1:0]                num_q, dsr_q;
  logic [camb_pkg::VecFracBits:0] quot_q;

  assign ge = (num_q >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(camb_pkg::VecFracBits)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // restoring division, numerator carries the half-divisor rounding term
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= (NumW'(mag_i) << camb_pkg::VecFracBits) + NumW'(len_i >> 1);
      dsr_q  <= NumW'(len_i) << camb_pkg::VecFracBits;
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        num_q <= num_q - dsr_q;
      end
      quot_q <= {quot_q[camb_pkg::VecFracBits-1:0], ge};
      dsr_q  <= dsr_q >> 1;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/camera_basis_and_move.sv
// Euler-angle camera: keeps a Q23.8 position and Q1.14 front/right/up unit vectors.
// Every accepted transaction returns one result holding the whole state after the
// update. An angles transaction (kind 0) is accepted, runs two CORDIC passes and
// the product steps, then three normalizations, each made of squaring steps, a
// serial square root, three restoring divisions and a commit, with the cross-product
// steps before the last, and ends with the output step. A move transaction (kind 1)
// runs on the shared multiplier. A stalled output register holds the transaction
// until it can take the result. One transaction is in flight at a time; the next is
// taken as soon as the result sits in the output register. If right degenerates at
// pitch near plus or minus 90 degrees, front is updated and right and up keep their
// previous values.
module camera_basis_and_move #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [13:0] pitch_angle_i,
  input  logic [1:0]         move_direction_i,
  input  logic signed [15:0] speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);

  localparam logic signed [33:0] PosMax = 34'sd2147483647;
  localparam logic signed [33:0] PosMin = -34'sd2147483648;

  camb_pkg::camb_state_e state_q, state_d;
  camb_pkg::camb_phase_e phase_q, phase_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [1:0]            cidx, pidx;
  logic                  out_valid_q, out_load;

  logic                  cord_start, sqrt_start, div_start;
  logic signed [15:0]    cord_angle;
  logic signed [31:0]    cord_cos, cord_sin;
  camb_pkg::unit_sts_t   cord_sts, sqrt_sts, div_sts;
  logic [31:0]           sqrt_root;
  logic [camb_pkg::VecFracBits:0] div_quot, quot_cap;

  logic signed [13:0]    pitch_q;
  logic [1:0]            dir_q;
  logic signed [15:0]    speed_q;
  logic signed [31:0]    cy_q, sy_q;
  camb_pkg::raw_t        raw_q [3];
  camb_pkg::raw_t        raw_sel, tmp_q;
  logic [31:0]           mag_sel, len_q;
  logic [63:0]           acc_q;
  camb_pkg::vec_t        nrm_q [3];
  camb_pkg::vec_t        nr_q [3];
  camb_pkg::vec_t        nrm_val, dvec_sel;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [65:0]    prod_q;

  camb_pkg::pos_t        pos_q [3];
  camb_pkg::vec_t        front_q [3];
  camb_pkg::vec_t        right_q [3];
  camb_pkg::vec_t        up_q [3];
  camb_pkg::pos_t        opos_q [3];
  camb_pkg::vec_t        ofront_q [3];
  camb_pkg::vec_t        oright_q [3];
  camb_pkg::vec_t        oup_q [3];

  camb_pkg::pos_t        pos_sel;
  logic signed [33:0]    step, pos_sum;
  camb_pkg::pos_t        pos_new;
  logic                  move_sub;

  camb_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .angle_i(cord_angle),
    .sts_o  (cord_sts),
    .cos_o  (cord_cos),
    .sin_o  (cord_sin)
  );

  camb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .x_i    (acc_q),
    .sts_o  (sqrt_sts),
    .root_o (sqrt_root)
  );

  camb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (mag_sel),
    .len_i  (len_q),
    .sts_o  (div_sts),
    .quot_o (div_quot)
  );

  assign cidx = cnt_q[1:0];
  assign pidx = cnt_q[1:0] - 2'd1;

  // operand selection shared by the square, divide and move steps
  always_comb begin
    case (cidx)
      2'd0:    raw_sel = raw_q[0];
      2'd1:    raw_sel = raw_q[1];
      2'd2:    raw_sel = raw_q[2];
      default: raw_sel = '0;
    endcase
    mag_sel = raw_sel[32] ? 32'(-raw_sel) : 32'(raw_sel);
    case (cidx)
      2'd0:    dvec_sel = (dir_q[1] == 1'b0) ? front_q[0] : right_q[0];
      2'd1:    dvec_sel = (dir_q[1] == 1'b0) ? front_q[1] : right_q[1];
      2'd2:    dvec_sel = (dir_q[1] == 1'b0) ? front_q[2] : right_q[2];
      default: dvec_sel = '0;
    endcase
    case (pidx)
      2'd0:    pos_sel = pos_q[0];
      2'd1:    pos_sel = pos_q[1];
      default: pos_sel = pos_q[2];
    endcase
  end

  // division result: cap at one, restore sign
  always_comb begin
    quot_cap = (div_quot > (camb_pkg::VecFracBits + 1)'(camb_pkg::VecOne)) ?
               (camb_pkg::VecFracBits + 1)'(camb_pkg::VecOne) : div_quot;
    nrm_val  = raw_sel[32] ? -16'($signed({1'b0, quot_cap})) :
                             16'($signed({1'b0, quot_cap}));
  end

  // move step with round half up and saturation
  always_comb begin
    move_sub = (dir_q == camb_pkg::DIR_BACK) || (dir_q == camb_pkg::DIR_LEFT);
    step     = 34'((prod_q + (66'sd1 <<< (camb_pkg::VecFracBits - 1)))
                   >>> camb_pkg::VecFracBits);
    pos_sum  = move_sub ? 34'(pos_sel) - step : 34'(pos_sel) + step;
    if (pos_sum > PosMax) begin
      pos_new = 32'(PosMax);
    end else if (pos_sum < PosMin) begin
      pos_new = 32'(PosMin);
    end else begin
      pos_new = 32'(pos_sum);
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    cord_start = 1'b0;
    cord_angle = yaw_angle_i;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      camb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (kind_i == camb_pkg::KindAngles) begin
            cord_start = 1'b1;
            state_d    = camb_pkg::S_CORD_Y;
          end else begin
            state_d = camb_pkg::S_MOVE;
          end
        end
      end
      camb_pkg::S_CORD_Y: begin
        if (cord_sts.done) begin
          cord_start = 1'b1;
          cord_angle = 16'(pitch_q);
          state_d    = camb_pkg::S_CORD_P;
        end
      end
      camb_pkg::S_CORD_P: begin
        if (cord_sts.done) begin
          cnt_d   = '0;
          state_d = camb_pkg::S_RAW;
        end
      end
      camb_pkg::S_RAW: begin
        mul_a = (cnt_q == 3'd0) ? 33'(cy_q) : 33'(sy_q);
        mul_b = 33'(cord_cos);
        if (cnt_q == 3'd2) begin
          cnt_d   = '0;
          phase_d = camb_pkg::PH_FRONT;
          state_d = camb_pkg::S_SQ;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      camb_pkg::S_SQ: begin
        mul_a = $signed({1'b0, mag_sel});
        mul_b = $signed({1'b0, mag_sel});
        if (cnt_q == 3'd3) begin
          state_d = camb_pkg::S_SQRT_GO;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      camb_pkg::S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = camb_pkg::S_SQRT;
      end
      camb_pkg::S_SQRT: begin
        if (sqrt_sts.done) begin
          cnt_d   = '0;
          state_d = (sqrt_root == 32'd0) ? camb_pkg::S_FIN : camb_pkg::S_DIV_GO;
        end
      end
      camb_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = camb_pkg::S_DIV;
      end
      camb_pkg::S_DIV: begin
        if (div_sts.done) begin
          if (cnt_q == 3'd2) begin
            state_d = camb_pkg::S_COMMIT;
          end else begin
            cnt_d   = cnt_q + 3'd1;
            state_d = camb_pkg::S_DIV_GO;
          end
        end
      end
      camb_pkg::S_COMMIT: begin
        cnt_d = '0;
        case (phase_q)
          camb_pkg::PH_FRONT: begin
            phase_d = camb_pkg::PH_RIGHT;
            state_d = camb_pkg::S_SQ;
          end
          camb_pkg::PH_RIGHT: state_d = camb_pkg::S_UPM;
          default:            state_d = camb_pkg::S_FIN;
        endcase
      end
      camb_pkg::S_UPM: begin
        // right x front, one product per cycle
        case (cnt_q)
          3'd0: begin mul_a = 33'(nr_q[1]); mul_b = 33'(front_q[2]); end
          3'd1: begin mul_a = 33'(nr_q[2]); mul_b = 33'(front_q[1]); end
          3'd2: begin mul_a = 33'(nr_q[2]); mul_b = 33'(front_q[0]); end
          3'd3: begin mul_a = 33'(nr_q[0]); mul_b = 33'(front_q[2]); end
          3'd4: begin mul_a = 33'(nr_q[0]); mul_b = 33'(front_q[1]); end
          3'd5: begin mul_a = 33'(nr_q[1]); mul_b = 33'(front_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q == 3'd6) begin
          cnt_d   = '0;
          phase_d = camb_pkg::PH_UP;
          state_d = camb_pkg::S_SQ;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      camb_pkg::S_MOVE: begin
        mul_a = 33'(dvec_sel);
        mul_b = 33'(speed_q);
        if (cnt_q == 3'd3) begin
          state_d = camb_pkg::S_FIN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      camb_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = camb_pkg::S_IDLE;
        end
      end
      default: state_d = camb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= camb_pkg::S_IDLE;
      phase_q     <= camb_pkg::PH_FRONT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= camb_pkg::PosResZ;
      front_q[0]  <= '0;
      front_q[1]  <= '0;
      front_q[2]  <= camb_pkg::VecOne;
      right_q[0]  <= camb_pkg::VecOne;
      right_q[1]  <= '0;
      right_q[2]  <= '0;
      up_q[0]     <= '0;
      up_q[1]     <= camb_pkg::VecOne;
      up_q[2]     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == camb_pkg::S_COMMIT) begin
        case (phase_q)
          camb_pkg::PH_FRONT: front_q <= nrm_q;
          camb_pkg::PH_UP: begin
            right_q <= nr_q;
            up_q    <= nrm_q;
          end
          default: ;
        endcase
      end
      if (state_q == camb_pkg::S_MOVE && cnt_q != 3'd0) begin
        case (pidx)
          2'd0:    pos_q[0] <= pos_new;
          2'd1:    pos_q[1] <= pos_new;
          default: pos_q[2] <= pos_new;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      camb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          pitch_q <= pitch_angle_i;
          dir_q   <= move_direction_i;
          speed_q <= speed_i;
        end
      end
      camb_pkg::S_CORD_Y: begin
        if (cord_sts.done) begin
          cy_q <= cord_cos;
          sy_q <= cord_sin;
        end
      end
      camb_pkg::S_RAW: begin
        if (cnt_q == 3'd1) begin
          raw_q[0] <= 33'(prod_q >>> camb_pkg::Q30Shift);
        end else if (cnt_q == 3'd2) begin
          raw_q[1] <= 33'(cord_sin);
          raw_q[2] <= 33'(prod_q >>> camb_pkg::Q30Shift);
        end
      end
      camb_pkg::S_SQ: begin
        if (cnt_q == 3'd0) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_q + prod_q[63:0];
        end
      end
      camb_pkg::S_SQRT: begin
        if (sqrt_sts.done) begin
          len_q <= sqrt_root;
        end
      end
      camb_pkg::S_DIV: begin
        if (div_sts.done) begin
          case (cidx)
            2'd0:    nrm_q[0] <= nrm_val;
            2'd1:    nrm_q[1] <= nrm_val;
            default: nrm_q[2] <= nrm_val;
          endcase
        end
      end
      camb_pkg::S_COMMIT: begin
        case (phase_q)
          camb_pkg::PH_FRONT: begin
            // front x world up
            raw_q[0] <= -(33'(nrm_q[2]) <<< camb_pkg::VecToQ30);
            raw_q[1] <= '0;
            raw_q[2] <= 33'(nrm_q[0]) <<< camb_pkg::VecToQ30;
          end
          camb_pkg::PH_RIGHT: nr_q <= nrm_q;
          default: ;
        endcase
      end
      camb_pkg::S_UPM: begin
        case (cnt_q)
          3'd1, 3'd3, 3'd5: tmp_q <= 33'(prod_q);
          3'd2: raw_q[0] <= (tmp_q - 33'(prod_q)) <<< camb_pkg::ProdToQ30;
          3'd4: raw_q[1] <= (tmp_q - 33'(prod_q)) <<< camb_pkg::ProdToQ30;
          3'd6: raw_q[2] <= (tmp_q - 33'(prod_q)) <<< camb_pkg::ProdToQ30;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      opos_q   <= pos_q;
      ofront_q <= front_q;
      oright_q <= right_q;
      oup_q    <= up_q;
    end
  end

  assign in_stall_o  = (state_q != camb_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = opos_q[0];
  assign pos_y_o     = opos_q[1];
  assign pos_z_o     = opos_q[2];
  assign front_x_o   = ofront_q[0];
  assign front_y_o   = ofront_q[1];
  assign front_z_o   = ofront_q[2];
  assign right_x_o   = oright_q[0];
  assign right_y_o   = oright_q[1];
  assign right_z_o   = oright_q[2];
  assign up_x_o      = oup_q[0];
  assign up_y_o      = oup_q[1];
  assign up_z_o      = oup_q[2];

  a_cord_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_start |-> !cord_sts.busy)
    else $error("cordic restarted while busy");

  a_units_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sqrt_start || div_start) |-> !(sqrt_sts.busy || div_sts.busy))
    else $error("root or divide unit restarted while busy");

  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_sts.done |-> state_q == camb_pkg::S_SQRT)
    else $error("square root finished outside its wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == camb_pkg::S_DIV)
    else $error("division finished outside its wait state");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == camb_pkg::S_FIN && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished transaction not presented");

endmodule
